### hw/rtl/mpeb_pkg.sv
`timescale 1ns / 1ps

package mpeb_pkg;

  localparam int unsigned LbaWidth    = 32;
  localparam int unsigned SptWidth    = 6;
  localparam int unsigned HeadsWidth  = 8;
  localparam int unsigned CylWidth    = 10;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 32;
  localparam int unsigned SlotWidth   = 2;
  localparam int unsigned SlotsWidth  = 3;
  localparam int unsigned DivisorWidth = 8;
  localparam int unsigned StepWidth   = $clog2(LbaWidth);

  localparam logic [SlotsWidth-1:0] NumSlots   = 3'd4;
  localparam logic [CylWidth-1:0]   CylLimit   = 10'((1 << 10) - 1);
  localparam logic [HeadsWidth:0]   HeadLimit  = 9'((1 << 8) - 1);
  localparam logic [SptWidth-1:0]   SptReset   = 6'd63;
  localparam logic [HeadsWidth-1:0] HeadsReset = 8'd16;
  localparam logic [LbaWidth-1:0]   LbaReset   = '0;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SPT   = 2'd0,
    REG_HEADS = 2'd1,
    REG_START = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CYL  = 2'd1,
    ERR_HEAD = 2'd2,
    ERR_FULL = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    start;
    logic [LbaWidth-1:0]     dividend;
    logic [DivisorWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [LbaWidth-1:0]     quotient;
    logic [DivisorWidth-1:0] remainder;
  } div_rsp_t;

endpackage

### hw/rtl/mpeb_div.sv
`timescale 1ns / 1ps

module mpeb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpeb_pkg::div_req_t req_i,
  output mpeb_pkg::div_rsp_t rsp_o
);
  import mpeb_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [StepWidth-1:0]    cnt_q;
  logic [DivisorWidth-1:0] rem_q, rem_d;
  logic [LbaWidth-1:0]     quo_q;
  logic [DivisorWidth-1:0] dvs_q;
  logic [DivisorWidth:0]   shifted;
  logic [DivisorWidth:0]   diff;
  logic                    fits;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    shifted = {rem_q, quo_q[LbaWidth-1]};
    fits    = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = fits ? diff[DivisorWidth-1:0] : shifted[DivisorWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == StepWidth'(LbaWidth - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[LbaWidth-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### hw/rtl/mbr_partition_entry_builder.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                         tuser
// s_axis    in         sector_count, partition_type, boot_status  mode
// m_axis    out        entry_low, entry_high                      slot_index, error_code
// cfg       in         write enable, register index, write data   -
//
// For a CHS entry, four divisions (launch, 32 steps, done) run one after another
// on the shared restoring divider, then the output register is loaded once it is free.
// A full table or a request without CHS skips the divisions and goes straight to
// loading the output register.
// Reset loads the default geometry and clears the running LBA and slot count.
// A new transaction is taken once the sequencer is idle, even while the last
// result still waits in the output register.

module mbr_partition_entry_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sector_count[31:0], partition_type[39:32], boot_status[47:40]
  input  logic [47:0]                         s_axis_tdata,
  // mode[0]
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // entry_low[63:0], entry_high[127:64]
  output logic [127:0]                        m_axis_tdata,
  // slot_index[1:0], error_code[3:2]
  output logic [3:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [mpeb_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [mpeb_pkg::CfgWidth-1:0]       cfg_wdata_i
);
  import mpeb_pkg::*;

  state_e state_q, state_d;
  logic [1:0] step_q, step_d;

  logic [SptWidth-1:0]   spt_q;
  logic [HeadsWidth-1:0] heads_q;
  logic [LbaWidth-1:0]   next_lba_q;
  logic [SlotsWidth-1:0] slots_q;

  logic [LbaWidth-1:0]   count_q;
  logic [7:0]            ptype_q;
  logic [7:0]            status_q;
  logic                  nochs_q;
  logic                  full_q;
  logic [SlotWidth-1:0]  slot_q;
  logic [LbaWidth-1:0]   first_q;
  logic [LbaWidth-1:0]   last_q;
  logic [LbaWidth-1:0]   track_q;

  logic [SptWidth-1:0]   bsec_q, esec_q;
  logic [HeadsWidth-1:0] bhead_q, ehead_q;
  logic [CylWidth-1:0]   bcyl_q, ecyl_q;
  logic                  bovf_q, eovf_q;

  logic                  out_valid_q;
  logic [127:0]          out_data_q;
  logic [3:0]            out_user_q;

  logic                  in_fire;
  logic                  table_full;
  logic                  out_load;
  logic                  store_div;
  logic [SptWidth-1:0]   spt_eff;
  logic [HeadsWidth-1:0] heads_eff;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  err_e                  err;
  logic [63:0]           entry_low;
  logic [63:0]           entry_high;

  assign spt_eff    = (spt_q == '0) ? SptWidth'(1) : spt_q;
  assign heads_eff  = (heads_q == '0) ? HeadsWidth'(1) : heads_q;
  assign table_full = slots_q >= NumSlots;
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  mpeb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Steps: begin track, begin cylinder/head, end track, end cylinder/head.
  always_comb begin
    div_req.start = 1'b0;
    case (step_q)
      2'd0:    div_req.dividend = first_q;
      2'd2:    div_req.dividend = last_q;
      default: div_req.dividend = track_q;
    endcase
    if (step_q[0]) begin
      div_req.divisor = heads_eff;
    end else begin
      div_req.divisor = {{(DivisorWidth-SptWidth){1'b0}}, spt_eff};
    end

    state_d   = state_q;
    step_d    = step_q;
    out_load  = 1'b0;
    store_div = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          step_d = 2'd0;
          if (table_full || s_axis_tuser[0]) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        div_req.start = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          store_div = 1'b1;
          if (step_q == 2'd3) begin
            state_d = ST_FINISH;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Geometry and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q      <= SptReset;
      heads_q    <= HeadsReset;
      next_lba_q <= LbaReset;
      slots_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SPT:   spt_q <= cfg_wdata_i[SptWidth-1:0];
        REG_HEADS: heads_q <= cfg_wdata_i[HeadsWidth-1:0];
        REG_START: begin
          next_lba_q <= cfg_wdata_i[LbaWidth-1:0];
          slots_q    <= '0;
        end
        default: ;
      endcase
    end else if (in_fire && !table_full) begin
      next_lba_q <= next_lba_q + s_axis_tdata[31:0];
      slots_q    <= slots_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q  <= s_axis_tdata[31:0];
      ptype_q  <= s_axis_tdata[39:32];
      status_q <= s_axis_tdata[47:40];
      nochs_q  <= s_axis_tuser[0];
      full_q   <= table_full;
      slot_q   <= slots_q[SlotWidth-1:0];
      first_q  <= next_lba_q;
      last_q   <= next_lba_q + s_axis_tdata[31:0] - LbaWidth'(1);
    end
    if (store_div) begin
      unique case (step_q)
        2'd0: begin
          track_q <= div_rsp.quotient;
          bsec_q  <= div_rsp.remainder[SptWidth-1:0] + SptWidth'(1);
        end
        2'd1: begin
          bhead_q <= div_rsp.remainder;
          bcyl_q  <= div_rsp.quotient[CylWidth-1:0];
          bovf_q  <= |div_rsp.quotient[LbaWidth-1:CylWidth];
        end
        2'd2: begin
          track_q <= div_rsp.quotient;
          esec_q  <= div_rsp.remainder[SptWidth-1:0] + SptWidth'(1);
        end
        default: begin
          ehead_q <= div_rsp.remainder;
          ecyl_q  <= div_rsp.quotient[CylWidth-1:0];
          eovf_q  <= |div_rsp.quotient[LbaWidth-1:CylWidth];
        end
      endcase
    end
  end

  // Error precedence is full table, cylinder range, head range; without CHS only full.
  always_comb begin
    if (full_q) begin
      err = ERR_FULL;
    end else if (nochs_q) begin
      err = ERR_NONE;
    end else if (bovf_q || eovf_q || (bcyl_q > CylLimit) || (ecyl_q > CylLimit)) begin
      err = ERR_CYL;
    end else if (({1'b0, bhead_q} > HeadLimit) || ({1'b0, ehead_q} > HeadLimit)) begin
      err = ERR_HEAD;
    end else begin
      err = ERR_NONE;
    end

    entry_low  = '0;
    entry_high = '0;
    if (err == ERR_NONE) begin
      entry_low[7:0]   = status_q;
      entry_low[39:32] = ptype_q;
      if (!nochs_q) begin
        entry_low[15:8]  = bhead_q;
        entry_low[23:16] = {bcyl_q[9:8], bsec_q};
        entry_low[31:24] = bcyl_q[7:0];
        entry_low[47:40] = ehead_q;
        entry_low[55:48] = {ecyl_q[9:8], esec_q};
        entry_low[63:56] = ecyl_q[7:0];
      end
      entry_high = {count_q, first_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {entry_high, entry_low};
      out_user_q <= {err, full_q ? SlotWidth'(0) : slot_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### test/mbr_partition_entry_builder_test.sv
`timescale 1ns / 1ps

module mbr_partition_entry_builder_test;
  import mpeb_pkg::*;

  localparam int unsigned RandomItems = 1650;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned MaxReports  = 10;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  ptype;
    logic [7:0]  status;
    logic        chs_off;
  } part_req_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0]  slot;
    err_e        err;
  } entry_t;

  class partition_table_checker;
    logic [SptWidth-1:0]   spt;
    logic [HeadsWidth-1:0] heads;
    logic [LbaWidth-1:0]   next_lba;
    logic [SlotsWidth-1:0] slots_used;
    entry_t                expected_entries[$];
    int unsigned           failures;

    function new();
      spt        = SptReset;
      heads      = HeadsReset;
      next_lba   = LbaReset;
      slots_used = '0;
      failures   = 0;
    endfunction

    function void note_config(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
      case (idx)
        REG_SPT: begin
          spt = value[SptWidth-1:0];
        end
        REG_HEADS: begin
          heads = value[HeadsWidth-1:0];
        end
        REG_START: begin
          next_lba   = value;
          slots_used = '0;
        end
        default: begin
        end
      endcase
    endfunction

    // Returns the three CHS bytes, head byte lowest, for one LBA.
    function logic [23:0] chs_bytes(logic [31:0] lba, output logic [31:0] cyl,
                                    output logic [31:0] head);
      logic [31:0] spt_e;
      logic [31:0] heads_e;
      logic [31:0] track;
      logic [31:0] sec;
      spt_e   = (spt == 0) ? 32'd1 : 32'(spt);
      heads_e = (heads == 0) ? 32'd1 : 32'(heads);
      track   = lba / spt_e;
      head    = track % heads_e;
      cyl     = track / heads_e;
      sec     = (lba % spt_e) + 32'd1;
      return {cyl[7:0], cyl[9:8], sec[5:0], head[7:0]};
    endfunction

    function void note_partition(part_req_t r);
      entry_t      e;
      logic [31:0] first;
      logic [31:0] last;
      logic [31:0] bcyl;
      logic [31:0] bhead;
      logic [31:0] ecyl;
      logic [31:0] ehead;
      logic [23:0] bchs;
      logic [23:0] echs;
      e = '0;
      if (slots_used >= NumSlots) begin
        e.err = ERR_FULL;
      end else begin
        first      = next_lba;
        last       = first + r.count - 32'd1;
        e.slot     = slots_used[1:0];
        next_lba   = first + r.count;
        slots_used = slots_used + 1'b1;
        e.err      = ERR_NONE;
        if (!r.chs_off) begin
          bchs = chs_bytes(first, bcyl, bhead);
          echs = chs_bytes(last, ecyl, ehead);
          if (bcyl > CylLimit || ecyl > CylLimit) begin
            e.err = ERR_CYL;
          end else if (bhead > HeadLimit || ehead > HeadLimit) begin
            e.err = ERR_HEAD;
          end else begin
            e.lo = {echs, 8'h00, bchs, 8'h00};
          end
        end
        if (e.err == ERR_NONE) begin
          e.lo[7:0]   = r.status;
          e.lo[39:32] = r.ptype;
          e.hi        = {r.count, first};
        end
      end
      expected_entries.push_back(e);
    endfunction

    function void check_entry(logic [127:0] data, logic [3:0] user);
      entry_t want;
      entry_t got;
      got.lo   = data[63:0];
      got.hi   = data[127:64];
      got.slot = user[1:0];
      got.err  = err_e'(user[3:2]);
      if (expected_entries.size() == 0) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("unexpected entry: lo %h hi %h slot %0d err %0d",
                   got.lo, got.hi, got.slot, got.err);
        end
        return;
      end
      want = expected_entries.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("entry mismatch: expected lo %h hi %h slot %0d err %0d",
                   want.lo, want.hi, want.slot, want.err);
          $display("                actual   lo %h hi %h slot %0d err %0d",
                   got.lo, got.hi, got.slot, got.err);
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [127:0]           m_axis_tdata;
  logic [3:0]             m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i     = '0;
  logic [CfgWidth-1:0]    cfg_wdata_i   = '0;

  partition_table_checker table_chk = new();

  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned hold_req      = 0;
  int unsigned holds_seen    = 0;
  int unsigned hold_left     = 0;

  mbr_partition_entry_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("mbr_partition_entry_builder_test: errors");
      $finish;
    end
  end

  // Result side: checks each transaction and applies random or long back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        table_chk.check_entry(m_axis_tdata, m_axis_tuser);
      end
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        hold_left  = LongHold;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_partition(part_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.status, r.ptype, r.count};
    s_axis_tuser  <= r.chs_off;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    table_chk.note_partition(r);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (table_chk.expected_entries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    table_chk.note_config(idx, value);
  endtask

  task automatic program_table(logic [31:0] spt, logic [31:0] heads, logic [31:0] start,
                               bit reload, bit poke_unused);
    write_reg(REG_SPT, spt);
    write_reg(REG_HEADS, heads);
    if (reload) begin
      write_reg(REG_START, start);
    end
    if (poke_unused) begin
      write_reg(RegUnused, 32'hffff_ffff);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_table();
    logic [31:0] spt;
    logic [31:0] heads;
    logic [31:0] span;
    logic [31:0] start;
    logic [31:0] count;
    int unsigned n;
    part_req_t   r;
    spt = $urandom_range(63, 1);
    if ($urandom_range(9) == 0) begin
      spt = $urandom_range(1) ? 32'd63 : 32'($urandom_range(1));
    end
    heads = $urandom_range(255, 1);
    if ($urandom_range(9) == 0) begin
      heads = $urandom_range(1) ? 32'd255 : 32'($urandom_range(1));
    end
    span = ((spt == 0) ? 32'd1 : spt) * ((heads == 0) ? 32'd1 : heads) * 32'd1024;
    case ($urandom_range(9))
      0: start = $urandom();
      1: start = 32'hffff_ffff - $urandom_range(255);
      2: start = '0;
      3: start = span - 32'd1 - $urandom_range(255);
      default: start = $urandom_range(span / 2);
    endcase
    n = ($urandom_range(3) == 0) ? $urandom_range(7, 1) : $urandom_range(5, 3);
    drain();
    program_table(spt, heads, start, $urandom_range(9) != 0, 1'b0);
    repeat (n) begin
      case ($urandom_range(9))
        0: count = $urandom();
        1: count = $urandom_range(3);
        2, 3: count = $urandom_range(span);
        default: count = $urandom_range(span / 8 + 1, 1);
      endcase
      r.count   = count;
      r.ptype   = 8'($urandom());
      r.status  = ($urandom_range(3) == 0) ? 8'h80 : 8'($urandom());
      r.chs_off = ($urandom_range(9) < 3);
      send_partition(r);
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default geometry straight after reset, including a zero count, an end LBA
    // that wraps and a full table.
    send_partition(part_req_t'{32'd1, 8'h00, 8'h80, 1'b0});
    send_partition(part_req_t'{32'd1007, 8'h0c, 8'h00, 1'b0});
    send_partition(part_req_t'{32'd0, 8'hff, 8'hff, 1'b0});
    send_partition(part_req_t'{32'hffff_ffff, 8'h83, 8'h7f, 1'b0});
    send_partition(part_req_t'{32'd5, 8'h07, 8'h80, 1'b1});
    drain();

    // Zero geometry is taken as one sector per track and one head.
    program_table(32'd0, 32'd0, 32'd5, 1'b1, 1'b0);
    send_partition(part_req_t'{32'd10, 8'h83, 8'h00, 1'b0});
    send_partition(part_req_t'{32'd1000, 8'h05, 8'h80, 1'b0});
    send_partition(part_req_t'{32'd10, 8'h0b, 8'h01, 1'b0});
    send_partition(part_req_t'{32'hffff_ffff, 8'hee, 8'h80, 1'b1});
    drain();

    // Largest geometry: the last addressable cylinder, then one beyond it.
    program_table(32'd63, 32'd255, 32'd16450559, 1'b1, 1'b0);
    send_partition(part_req_t'{32'd1, 8'h0f, 8'h80, 1'b0});
    send_partition(part_req_t'{32'd1, 8'h0f, 8'h00, 1'b0});
    send_partition(part_req_t'{32'h8000_0000, 8'h55, 8'haa, 1'b1});
    send_partition(part_req_t'{32'd1, 8'haa, 8'h55, 1'b1});
    drain();

    // The running LBA wraps; a write to the unused index must change nothing.
    program_table(32'd1, 32'd1, 32'hffff_fff0, 1'b1, 1'b1);
    send_partition(part_req_t'{32'h20, 8'h07, 8'h80, 1'b1});
    send_partition(part_req_t'{32'd1, 8'h0c, 8'h00, 1'b0});
    send_partition(part_req_t'{32'd1008, 8'h0c, 8'h00, 1'b0});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct <= 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (phase == 2) begin
        // The result side stalls for a long time while entries keep coming,
        // so that the output register fills and the input side backs up.
        drain();
        program_table(32'd63, 32'd16, 32'd0, 1'b1, 1'b0);
        hold_req <= hold_req + 1;
        repeat (10) begin
          send_partition(part_req_t'{32'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1});
        end
      end
      goal = items_sent + RandomItems / 3;
      while (items_sent < goal) begin
        run_table();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (table_chk.failures == 0 && table_chk.expected_entries.size() == 0) begin
      $display("mbr_partition_entry_builder_test: clean");
    end else begin
      $display("mbr_partition_entry_builder_test: errors");
    end
    $finish;
  end

endmodule
